// ===== src/msfl_pkg.sv =====
// msfl_pkg: shared types and constants for the multi-stack shared free list
// no dependencies; imported by multi_stack_shared_free_list
package msfl_pkg;

  // sizing
  localparam int NUM_STACKS = 8;
  localparam int SLOT_COUNT = 256;
  localparam int ADDR_W     = $clog2(SLOT_COUNT);
  localparam int PTR_W      = $clog2(SLOT_COUNT + 1);
  localparam int VALUE_W    = 32;
  localparam int SIDX_W     = 3;
  localparam int CFG_W      = 4;

  // end-of-chain marker and reset values
  localparam logic [PTR_W-1:0]   END_MARK      = PTR_W'(SLOT_COUNT);
  localparam logic [CFG_W-1:0]   STACKS_RESET  = CFG_W'(8);
  localparam logic [VALUE_W-1:0] EMPTY_VALUE   = 32'h7FFF_FFFF;

  // operation codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_BAD   = 2'd3;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_state_t;

  typedef struct packed {
    logic                      func;
    logic [SIDX_W-1:0]         stack_index;
    logic signed [VALUE_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [1:0]                status;
  } out_item_t;

endpackage

// ===== src/msfl_ram.sv =====
// msfl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module msfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/multi_stack_shared_free_list.sv =====
// multi_stack_shared_free_list: several lifo stacks sharing one slot pool via a free list
// timing: an item is taken in FSM_IDLE and its result is registered on the FSM_EXEC commit, which
// waits while out_stall holds a valid result; no new item is taken before that commit (rams read, then written)
// reset: synchronous active-low rst_n; all stacks empty, free list from slot 0, no
// clearing pass (untouched slots are tracked by a fill count), stacks_in_use = 8
module multi_stack_shared_free_list
  import msfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  fsm_state_t state_r, state_nxt;

  logic [CFG_W-1:0] stacks_in_use_r;
  logic [PTR_W-1:0] tops_r [NUM_STACKS];
  logic [PTR_W-1:0] tops_nxt [NUM_STACKS];
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] addr_r;
  in_item_t         item_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             accept;
  logic             rd_en;
  logic             commit;
  logic [PTR_W-1:0] rd_slot;

  logic                  val_wr_en;
  logic [VALUE_W-1:0]    val_rd;
  logic                  lnk_wr_en;
  logic [PTR_W-1:0]      lnk_wr_data;
  logic [PTR_W-1:0]      lnk_rd;

  logic             bad_idx;
  logic             slot_ok;
  logic [PTR_W-1:0] link_raw;
  logic [PTR_W-1:0] link_eff;
  logic [PTR_W-1:0] top_cur;

  assign accept = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        rd_en    = in_valid;
      end
      FSM_EXEC: begin
        commit = !out_valid_r || !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // slot to read: free head for push, stack top for pop
  assign rd_slot = (in_item.func == FUNC_PUSH) ? free_head_r : tops_r[in_item.stack_index];

  // value and link stores
  msfl_ram #(.WIDTH(VALUE_W), .DEPTH(SLOT_COUNT)) u_value_ram (
    .clk     (clk),
    .wr_en   (val_wr_en),
    .wr_addr (addr_r[ADDR_W-1:0]),
    .wr_data (item_r.push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_slot[ADDR_W-1:0]),
    .rd_data (val_rd)
  );

  msfl_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk     (clk),
    .wr_en   (lnk_wr_en),
    .wr_addr (addr_r[ADDR_W-1:0]),
    .wr_data (lnk_wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_slot[ADDR_W-1:0]),
    .rd_data (lnk_rd)
  );

  // decode of the held item
  assign top_cur = tops_r[item_r.stack_index];
  assign bad_idx = ({1'b0, item_r.stack_index} >= stacks_in_use_r) ||
                   (32'(item_r.stack_index) >= NUM_STACKS);
  assign slot_ok = addr_r < END_MARK;

  // slots at or above the fill count were never written and still link to the next slot
  assign link_raw = (addr_r >= fill_r) ? (addr_r + PTR_W'(1)) : lnk_rd;
  assign link_eff = (link_raw > END_MARK) ? END_MARK : link_raw;

  // read-modify-write of the chains and the result
  always_comb begin
    tops_nxt      = tops_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    val_wr_en     = 1'b0;
    lnk_wr_en     = 1'b0;
    lnk_wr_data   = top_cur;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (commit) begin
      out_valid_nxt     = 1'b1;
      out_nxt.pop_value = '0;
      out_nxt.status    = STS_OK;
      priority if (bad_idx) begin
        out_nxt.status = STS_BAD;
      end else if (item_r.func == FUNC_PUSH) begin
        if (!slot_ok) begin
          out_nxt.status = STS_FULL;
        end else begin
          val_wr_en                     = 1'b1;
          lnk_wr_en                     = 1'b1;
          lnk_wr_data                   = top_cur;
          tops_nxt[item_r.stack_index]  = addr_r;
          free_head_nxt                 = link_eff;
          if (addr_r == fill_r) begin
            fill_nxt = fill_r + PTR_W'(1);
          end
        end
      end else begin
        if (!slot_ok) begin
          out_nxt.status    = STS_EMPTY;
          out_nxt.pop_value = EMPTY_VALUE;
        end else begin
          out_nxt.pop_value            = val_rd;
          tops_nxt[item_r.stack_index] = link_eff;
          lnk_wr_en                    = 1'b1;
          lnk_wr_data                  = free_head_r;
          free_head_nxt                = addr_r;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= FSM_IDLE;
      stacks_in_use_r <= STACKS_RESET;
      free_head_r     <= '0;
      fill_r          <= '0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        tops_r[i] <= END_MARK;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      tops_r      <= tops_nxt;
      if (cfg_wr_en) begin
        stacks_in_use_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
      addr_r <= rd_slot;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule
